// ----- hw/rtl/circular_deque_macros.svh -----
// assertion macros for the circular deque
`ifndef CIRCULAR_DEQUE_MACROS_SVH
`define CIRCULAR_DEQUE_MACROS_SVH

`ifndef NO_ASSERTIONS
// same-cycle implication, checked at every rising clock edge outside reset
`define CDQ_ASSERT_IMPL(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);
// next-cycle implication, checked at every rising clock edge outside reset
`define CDQ_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);
`else
`define CDQ_ASSERT_IMPL(label, ante, cons, msg)
`define CDQ_ASSERT_NEXT(label, ante, cons, msg)
`endif

`endif

// ----- hw/rtl/cdq_pkg.sv -----
package cdq_pkg;

  localparam int DEPTH         = 16;
  localparam int IDX_W         = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W         = $clog2(DEPTH + 1);
  localparam int VAL_W         = 32;
  localparam int COUNT_FIELD_W = 5;

  typedef enum logic [1:0] {
    CMD_INS_FRONT = 2'd0,
    CMD_INS_REAR  = 2'd1,
    CMD_DEL_FRONT = 2'd2,
    CMD_DEL_REAR  = 2'd3
  } cmd_t;

  typedef enum logic [1:0] {
    ST_DONE  = 2'd0,
    ST_FULL  = 2'd1,
    ST_EMPTY = 2'd2
  } status_t;

  typedef struct packed {
    cmd_t              cmd;
    logic signed [31:0] item_value;
  } in_word_t;

  typedef struct packed {
    status_t                    status;
    logic signed [31:0]         removed_value;
    logic [COUNT_FIELD_W-1:0]   item_count;
    logic                       now_empty;
    logic                       now_full;
  } out_word_t;

  // pointer unit outcome for the command on its input
  typedef struct packed {
    status_t          status;
    logic             we;
    logic             re;
    logic [IDX_W-1:0] addr;
    logic [CNT_W-1:0] count;
  } ptr_res_t;

endpackage

// ----- hw/rtl/cdq_ram.sv -----
module cdq_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16
) (
  input  logic                                      clk,
  input  logic                                      we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] addr,
  input  logic [WIDTH-1:0]                          wdata,
  output logic [WIDTH-1:0]                          rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end

endmodule

// ----- hw/rtl/cdq_ptr.sv -----
module cdq_ptr (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              step,
  input  cdq_pkg::cmd_t     cmd,
  output cdq_pkg::ptr_res_t res
);

  import cdq_pkg::*;

  logic [IDX_W-1:0] head_r, head_nxt;
  logic [IDX_W-1:0] tail_r, tail_nxt;
  logic             empty_r, empty_nxt;
  logic [CNT_W-1:0] count_r, count_nxt;
  logic             full;

  function automatic logic [IDX_W-1:0] wrap_up(input logic [IDX_W-1:0] i);
    return (i == IDX_W'(DEPTH - 1)) ? '0 : i + IDX_W'(1);
  endfunction

  function automatic logic [IDX_W-1:0] wrap_down(input logic [IDX_W-1:0] i);
    return (i == '0) ? IDX_W'(DEPTH - 1) : i - IDX_W'(1);
  endfunction

  assign full = (count_r == CNT_W'(DEPTH));

  always_comb begin
    head_nxt   = head_r;
    tail_nxt   = tail_r;
    empty_nxt  = empty_r;
    count_nxt  = count_r;
    res.status = ST_DONE;
    res.we     = 1'b0;
    res.re     = 1'b0;
    res.addr   = head_r;
    unique case (cmd)
      CMD_INS_FRONT, CMD_INS_REAR: begin
        if (full) begin
          res.status = ST_FULL;
        end else begin
          res.we    = 1'b1;
          count_nxt = count_r + CNT_W'(1);
          if (empty_r) begin
            // first element always lands in slot zero
            head_nxt  = '0;
            tail_nxt  = '0;
            empty_nxt = 1'b0;
            res.addr  = '0;
          end else if (cmd == CMD_INS_FRONT) begin
            head_nxt = wrap_down(head_r);
            res.addr = head_nxt;
          end else begin
            tail_nxt = wrap_up(tail_r);
            res.addr = tail_nxt;
          end
        end
      end
      CMD_DEL_FRONT, CMD_DEL_REAR: begin
        if (empty_r) begin
          res.status = ST_EMPTY;
        end else begin
          res.re    = 1'b1;
          res.addr  = (cmd == CMD_DEL_FRONT) ? head_r : tail_r;
          count_nxt = count_r - CNT_W'(1);
          if (head_r == tail_r) begin
            head_nxt  = '0;
            tail_nxt  = '0;
            empty_nxt = 1'b1;
          end else if (cmd == CMD_DEL_FRONT) begin
            head_nxt = wrap_up(head_r);
          end else begin
            tail_nxt = wrap_down(tail_r);
          end
        end
      end
    endcase
    res.count = count_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      head_r  <= '0;
      tail_r  <= '0;
      empty_r <= 1'b1;
      count_r <= '0;
    end else if (step) begin
      head_r  <= head_nxt;
      tail_r  <= tail_nxt;
      empty_r <= empty_nxt;
      count_r <= count_nxt;
    end
  end

endmodule

// ----- hw/rtl/circular_deque.sv -----
// Double-ended queue of DEPTH signed 32-bit elements in a circular slot
// memory. Each input word carries one command (insert front, insert rear,
// delete front, delete rear) and yields exactly one result word with the
// outcome, the removed element, the element count after the command and the
// empty/full flags. Inserts into a full deque and deletes from an empty one
// leave the contents alone and report so in the status. An insert or an
// ignored command has its result registered at acceptance; a successful
// delete first waits in the read state for the registered read data of the
// slot memory. A new word is taken in the cycle its predecessor's result
// is taken, so inserts sustain one word per cycle while out_ready stays
// high; a delete holds off the next word during its read wait. Slots need
// no clearing after reset: a delete only reads slots an earlier insert wrote.
module circular_deque (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  cdq_pkg::in_word_t  in_data,
  output logic               out_valid,
  input  logic               out_ready,
  output cdq_pkg::out_word_t out_data
);

  import cdq_pkg::*;

`include "circular_deque_macros.svh"

  // idle takes a word; rd waits on the memory read of a delete
  typedef enum logic {
    S_IDLE,
    S_RD
  } state_t;

  state_t           state_r;
  logic             out_valid_r;
  out_word_t        out_r;
  logic             step;
  ptr_res_t         res;
  logic [VAL_W-1:0] rdata;

  // take a word only in idle, when the result register is free or being drained
  assign in_ready  = (state_r == S_IDLE) && (!out_valid_r || out_ready);
  assign step      = in_valid && in_ready;
  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  // head/tail/count bookkeeping and slot address
  cdq_ptr u_ptr (
    .clk   (clk),
    .rst_n (rst_n),
    .step  (step),
    .cmd   (in_data.cmd),
    .res   (res)
  );

  // slot memory: written on a successful insert, read for a successful delete
  cdq_ram #(
    .WIDTH (VAL_W),
    .DEPTH (DEPTH)
  ) u_slots (
    .clk   (clk),
    .we    (step && res.we),
    .addr  (res.addr),
    .wdata (in_data.item_value),
    .rdata (rdata)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      unique case (state_r)
        S_IDLE: begin
          if (step) begin
            // everything but the removed element is known at acceptance
            out_r.status        <= res.status;
            out_r.removed_value <= '0;
            out_r.item_count    <= COUNT_FIELD_W'(res.count);
            out_r.now_empty     <= (res.count == '0);
            out_r.now_full      <= (res.count == CNT_W'(DEPTH));
            if (res.re) begin
              // any older word is drained this cycle
              state_r     <= S_RD;
              out_valid_r <= 1'b0;
            end else begin
              out_valid_r <= 1'b1;
            end
          end else if (out_valid_r && out_ready) begin
            out_valid_r <= 1'b0;
          end
        end
        S_RD: begin
          // read data of the delete is back: complete the result word
          out_r.removed_value <= rdata;
          out_valid_r         <= 1'b1;
          state_r             <= S_IDLE;
        end
      endcase
    end
  end

  // the result register is always free when delete data comes back
  `CDQ_ASSERT_IMPL(a_rd_out_free, state_r == S_RD, !out_valid_r,
                   "delete read returned while result register was busy")
  // a successful delete always goes through the read wait
  `CDQ_ASSERT_NEXT(a_del_reads, step && res.re, state_r == S_RD && !out_valid_r,
                   "successful delete did not wait on the memory read")
  // flags in the result word agree with its count and status
  `CDQ_ASSERT_IMPL(a_flags_consistent, out_valid_r,
                   (out_r.now_empty == (out_r.item_count == '0)) &&
                   (out_r.status != ST_FULL || out_r.now_full) &&
                   (out_r.status != ST_EMPTY || out_r.now_empty),
                   "result flags disagree with count or status")

endmodule
